/* rtl/cext_pkg.sv */
`default_nettype none

package cext_pkg;

	localparam int unsigned LINE_WIDTH   = 24;
	localparam int unsigned COLUMN_WIDTH = 16;

	// one result as it leaves the block
	typedef struct packed {
		logic                    kind;
		logic [7:0]              body_byte;
		logic                    multiline;
		logic [LINE_WIDTH-1:0]   begin_line;
		logic [COLUMN_WIDTH-1:0] begin_column;
		logic [LINE_WIDTH-1:0]   end_line;
		logic [COLUMN_WIDTH-1:0] end_column;
		logic                    run_end;
	} cext_res_t;

	// up to three results produced by one accepted request
	typedef struct packed {
		logic [1:0]      cnt;
		cext_res_t [2:0] res;
	} cext_push_t;

endpackage

`default_nettype wire

/* rtl/cext_scan.sv */
`default_nettype none

module cext_scan (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic [7:0]        in_byte,
	input  wire logic              stream_end,
	output cext_pkg::cext_push_t   push
);
	import cext_pkg::*;

	localparam logic [2:0] M_NORMAL   = 3'd0;
	localparam logic [2:0] M_NORMAL_Q = 3'd1;
	localparam logic [2:0] M_STRING   = 3'd2;
	localparam logic [2:0] M_STR_ESC  = 3'd3;
	localparam logic [2:0] M_LINE     = 3'd4;
	localparam logic [2:0] M_BLOCK    = 3'd5;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_BSL   = 8'h5C;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_U8_0  = 8'hE2;
	localparam logic [7:0] CH_U8_1  = 8'h80;
	localparam logic [7:0] CH_LQUOT = 8'h9C;
	localparam logic [7:0] CH_RQUOT = 8'h9D;

	localparam logic [LINE_WIDTH-1:0]   LINE_MAX = {LINE_WIDTH{1'b1}};
	localparam logic [COLUMN_WIDTH-1:0] COL_MAX  = {COLUMN_WIDTH{1'b1}};
	localparam logic [LINE_WIDTH-1:0]   LINE_ONE = LINE_WIDTH'(1);
	localparam logic [COLUMN_WIDTH-1:0] COL_ONE  = COLUMN_WIDTH'(1);

	logic [2:0]              mode_q, mode_d;
	logic [1:0]              mp_q, mp_d;
	logic [LINE_WIDTH-1:0]   cur_line_q, open_line_q, open_line_d, after_line;
	logic [COLUMN_WIDTH-1:0] cur_col_q, open_col_q, open_col_d, after_col;

	function automatic cext_res_t mk_body(input logic [7:0] b, input logic multi,
			input logic [LINE_WIDTH-1:0] ol, input logic [COLUMN_WIDTH-1:0] oc);
		cext_res_t r;
		r              = '0;
		r.kind         = 1'b0;
		r.body_byte    = b;
		r.multiline    = multi;
		r.begin_line   = ol;
		r.begin_column = oc;
		return r;
	endfunction

	function automatic cext_res_t mk_rec(input logic multi,
			input logic [LINE_WIDTH-1:0] ol, input logic [COLUMN_WIDTH-1:0] oc,
			input logic [LINE_WIDTH-1:0] el, input logic [COLUMN_WIDTH-1:0] ec);
		cext_res_t r;
		r              = '0;
		r.kind         = 1'b1;
		r.multiline    = multi;
		r.begin_line   = ol;
		r.begin_column = oc;
		r.end_line     = el;
		r.end_column   = ec;
		return r;
	endfunction

	// position just after this byte, saturating
	always_comb begin
		if (in_byte == CH_LF) begin
			after_line = (cur_line_q == LINE_MAX) ? LINE_MAX : cur_line_q + LINE_ONE;
			after_col  = COL_ONE;
		end else begin
			after_line = cur_line_q;
			after_col  = (cur_col_q == COL_MAX) ? COL_MAX : cur_col_q + COL_ONE;
		end
	end

	always_comb begin
		logic       fall;
		logic [2:0] fmode;
		logic [1:0] fmp;
		logic [1:0] cnt;
		cext_res_t [2:0] res;

		mode_d      = mode_q;
		mp_d        = mp_q;
		open_line_d = open_line_q;
		open_col_d  = open_col_q;
		fall        = 1'b0;
		fmode       = M_NORMAL;
		fmp         = 2'd0;
		cnt         = 2'd0;
		res         = '0;

		// first look: finish a partial multi-byte match or hand over to a fresh scan
		case (mode_q)
			M_NORMAL: begin
				fall  = 1'b1;
				fmode = M_NORMAL;
				fmp   = mp_q;
			end
			M_NORMAL_Q: begin
				if (mp_q == 2'd1 && in_byte == CH_U8_1) begin
					mp_d = 2'd2;
				end else if (mp_q == 2'd2 && in_byte == CH_LQUOT) begin
					mode_d = M_STRING;
					mp_d   = 2'd0;
				end else begin
					fall  = 1'b1;
					fmode = M_NORMAL;
				end
			end
			M_STRING: begin
				if (mp_q == 2'd0) begin
					fall  = 1'b1;
					fmode = M_STRING;
				end else if (mp_q == 2'd1 && in_byte == CH_U8_1) begin
					mp_d = 2'd2;
				end else if (mp_q == 2'd2 && in_byte == CH_RQUOT) begin
					mode_d = M_NORMAL;
					mp_d   = 2'd0;
				end else begin
					fall  = 1'b1;
					fmode = M_STRING;
				end
			end
			M_STR_ESC: begin
				if (mp_q == 2'd0 && in_byte == CH_QUOTE) begin
					mode_d = M_STRING;
				end else if (mp_q == 2'd0 && in_byte == CH_U8_0) begin
					mp_d = 2'd1;
				end else if (mp_q == 2'd1 && in_byte == CH_U8_1) begin
					mp_d = 2'd2;
				end else if (mp_q == 2'd2 && in_byte == CH_RQUOT) begin
					mode_d = M_STRING;
					mp_d   = 2'd0;
				end else begin
					fall  = 1'b1;
					fmode = M_STRING;
				end
			end
			M_LINE: begin
				if (in_byte == CH_LF) begin
					res[cnt] = mk_rec(1'b0, open_line_q, open_col_q, cur_line_q, cur_col_q);
					cnt      = cnt + 2'd1;
					mode_d   = M_NORMAL;
					mp_d     = 2'd0;
				end else begin
					res[cnt] = mk_body(in_byte, 1'b0, open_line_q, open_col_q);
					cnt      = cnt + 2'd1;
				end
			end
			M_BLOCK: begin
				if (mp_q == 2'd0) begin
					if (in_byte == CH_STAR) begin
						mp_d = 2'd1;
					end else begin
						res[cnt] = mk_body(in_byte, 1'b1, open_line_q, open_col_q);
						cnt      = cnt + 2'd1;
					end
				end else if (in_byte == CH_SLASH) begin
					res[cnt] = mk_rec(1'b1, open_line_q, open_col_q, after_line, after_col);
					cnt      = cnt + 2'd1;
					mode_d   = M_NORMAL;
					mp_d     = 2'd0;
				end else if (in_byte == CH_STAR) begin
					// star run: emit the held star, keep the new one pending
					res[cnt] = mk_body(CH_STAR, 1'b1, open_line_q, open_col_q);
					cnt      = cnt + 2'd1;
				end else begin
					res[cnt] = mk_body(CH_STAR, 1'b1, open_line_q, open_col_q);
					cnt      = cnt + 2'd1;
					res[cnt] = mk_body(in_byte, 1'b1, open_line_q, open_col_q);
					cnt      = cnt + 2'd1;
					mp_d     = 2'd0;
				end
			end
			default: begin
				fall  = 1'b1;
				fmode = M_NORMAL;
			end
		endcase

		// second look: byte examined afresh in plain text or inside a string
		if (fall) begin
			if (fmode == M_NORMAL) begin
				if (fmp == 2'd1 && in_byte == CH_DASH) begin
					mode_d = M_LINE;
					mp_d   = 2'd0;
				end else if (fmp == 2'd2 && in_byte == CH_STAR) begin
					mode_d = M_BLOCK;
					mp_d   = 2'd0;
				end else begin
					mode_d = M_NORMAL;
					mp_d   = 2'd0;
					if (in_byte == CH_QUOTE) begin
						mode_d = M_STRING;
					end else if (in_byte == CH_U8_0) begin
						mode_d = M_NORMAL_Q;
						mp_d   = 2'd1;
					end else if (in_byte == CH_DASH || in_byte == CH_SLASH) begin
						mp_d        = (in_byte == CH_DASH) ? 2'd1 : 2'd2;
						open_line_d = cur_line_q;
						open_col_d  = cur_col_q;
					end
				end
			end else begin
				mode_d = M_STRING;
				mp_d   = 2'd0;
				if (in_byte == CH_QUOTE) begin
					mode_d = M_NORMAL;
				end else if (in_byte == CH_U8_0) begin
					mp_d = 2'd1;
				end else if (in_byte == CH_BSL) begin
					mode_d = M_STR_ESC;
				end
			end
		end

		// last byte: close an open comment
		if (stream_end) begin
			if (mode_d == M_BLOCK) begin
				if (mp_d != 2'd0) begin
					res[cnt] = mk_body(CH_STAR, 1'b1, open_line_d, open_col_d);
					cnt      = cnt + 2'd1;
				end
				res[cnt] = mk_rec(1'b1, open_line_d, open_col_d, after_line, after_col);
				cnt      = cnt + 2'd1;
			end else if (mode_d == M_LINE) begin
				res[cnt] = mk_rec(1'b0, open_line_d, open_col_d, after_line, after_col);
				cnt      = cnt + 2'd1;
			end
		end

		if (cnt != 2'd0) begin
			res[cnt - 2'd1].run_end = 1'b1;
		end

		push.cnt = cnt;
		push.res = res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= M_NORMAL;
			mp_q        <= 2'd0;
			cur_line_q  <= LINE_ONE;
			cur_col_q   <= COL_ONE;
			open_line_q <= LINE_ONE;
			open_col_q  <= COL_ONE;
		end else if (accept) begin
			if (stream_end) begin
				// back to the start of a new source
				mode_q      <= M_NORMAL;
				mp_q        <= 2'd0;
				cur_line_q  <= LINE_ONE;
				cur_col_q   <= COL_ONE;
				open_line_q <= LINE_ONE;
				open_col_q  <= COL_ONE;
			end else begin
				mode_q      <= mode_d;
				mp_q        <= mp_d;
				cur_line_q  <= after_line;
				cur_col_q   <= after_col;
				open_line_q <= open_line_d;
				open_col_q  <= open_col_d;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/cext_rbuf.sv */
`default_nettype none

module cext_rbuf (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire cext_pkg::cext_push_t wr,
	output logic                      room,
	output logic                      rd_valid,
	input  wire logic                 rd_ready,
	output cext_pkg::cext_res_t       rd
);
	import cext_pkg::*;

	cext_res_t  mem_q [4];
	logic [1:0] wr_ptr_q, rd_ptr_q;
	logic [2:0] count_q;
	logic       pop;
	logic [1:0] n_push;

	// room for the largest burst of one request
	assign room     = (count_q <= 3'd1);
	assign rd_valid = (count_q != 3'd0);
	assign rd       = mem_q[rd_ptr_q];
	assign pop      = rd_valid && rd_ready;
	assign n_push   = wr_en ? wr.cnt : 2'd0;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < n_push) begin
				mem_q[wr_ptr_q + 2'(i)] <= wr.res[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push;
			rd_ptr_q <= rd_ptr_q + {1'b0, pop};
			count_q  <= count_q + {1'b0, n_push} - {2'b00, pop};
		end
	end

endmodule

`default_nettype wire

/* rtl/comment_extractor.sv */
`default_nettype none

// Comment extractor: takes one source byte per request and returns comment body
// bytes and one completion record per comment, skipping comments inside plain
// or smart-quoted strings. A byte is scanned in the cycle it is accepted and its
// zero to three results go into a four-entry result queue. A new byte is taken in
// every cycle in which the queue holds at most one result, and the output side
// moves one result per cycle while out_ready is high. Plain text and comment
// bodies therefore run at one byte per cycle when the output does not stall,
// while a byte that gives two or three results (a held star let go with the
// byte after it, or a comment closed on the last byte) holds the input until
// the queue drains. Back pressure on the output stalls the input once two
// results are waiting. The first result of a byte can leave at the edge after
// the one that accepts it, later if older results are still queued ahead of it.
module comment_extractor (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic [7:0]                          in_byte,
	input  wire logic                                stream_end,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic                                     kind,
	output logic [7:0]                               body_byte,
	output logic                                     multiline,
	output logic [cext_pkg::LINE_WIDTH-1:0]          begin_line,
	output logic [cext_pkg::COLUMN_WIDTH-1:0]        begin_column,
	output logic [cext_pkg::LINE_WIDTH-1:0]          end_line,
	output logic [cext_pkg::COLUMN_WIDTH-1:0]        end_column,
	output logic                                     run_end
);
	import cext_pkg::*;

	logic       accept;
	logic       room;
	cext_push_t push;
	cext_res_t  rd;

	assign in_ready = room;
	assign accept   = in_valid && room;

	cext_scan u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.in_byte    (in_byte),
		.stream_end (stream_end),
		.push       (push)
	);

	cext_rbuf u_rbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept),
		.wr       (push),
		.room     (room),
		.rd_valid (out_valid),
		.rd_ready (out_ready),
		.rd       (rd)
	);

	assign kind         = rd.kind;
	assign body_byte    = rd.body_byte;
	assign multiline    = rd.multiline;
	assign begin_line   = rd.begin_line;
	assign begin_column = rd.begin_column;
	assign end_line     = rd.end_line;
	assign end_column   = rd.end_column;
	assign run_end      = rd.run_end;

endmodule

`default_nettype wire
